### src/pab_pkg.sv
// Shared types and defaults for the pair assignment bitmap set.
// Used by pab_store and pair_assignment_bitmap_set; depends on nothing.
package pab_pkg;

    localparam int DEF_MAX_PREDICATES = 16;
    localparam int DEF_MAX_ARITY      = 4;
    localparam int DEF_MAX_OBJECTS    = 16;

    localparam int FIELD_W = 4;   // width of predicate, object and parameter fields
    localparam int COUNT_W = 3;   // saturating position counters
    localparam int LIMIT_W = 4;   // arity after limiting, holds up to fifteen

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_BIND    = 2'd1,
        OP_LITERAL = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_READ,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic clear_start;
    } store_ctl_t;

endpackage

### src/pab_store.sv
// One-bit-wide store of single and pair bits with a registered read port.
// Runs its own clearing sweep after reset and on request; depends on pab_pkg.
module pab_store
    import pab_pkg::*;
#(
    parameter int DEPTH  = 2,
    parameter int ADDR_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  store_ctl_t        ctl,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [ADDR_W-1:0] raddr,
    output logic              rdata,
    output logic              clearing
);

    logic              mem [DEPTH];
    logic              rdata_reg;
    logic              clear_reg;
    logic              clear_next;
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] cnt_next;
    logic              last_entry;

    assign last_entry = (cnt_reg == ADDR_W'(DEPTH - 1));

    always_comb
    begin
        clear_next = clear_reg;
        cnt_next   = cnt_reg;
        if (clear_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (last_entry)
            begin
                clear_next = 1'b0;
                cnt_next   = '0;
            end
        end
        else if (ctl.clear_start)
        begin
            clear_next = 1'b1;
            cnt_next   = '0;
        end
    end

    // The store comes out of reset uncleared, so the sweep starts right away.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg <= 1'b1;
            cnt_reg   <= '0;
        end
        else
        begin
            clear_reg <= clear_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_reg)
            mem[cnt_reg] <= 1'b0;
        else if (ctl.wr_en)
            mem[waddr] <= 1'b1;
        rdata_reg <= mem[raddr];
    end

    assign rdata    = rdata_reg;
    assign clearing = clear_reg;

endmodule

### src/pair_assignment_bitmap_set.sv
// Top level of the pair assignment bitmap set: command port, sequencer and
// literal evaluation around one pab_store. Depends on pab_pkg and pab_store.

// Each beat taken on start is one command. The last term of a literal is
// resolved, then read from the store in ST_READ and judged in ST_EVAL, and
// on the last literal all_consistent comes with result_valid for one cycle.
// The last argument of an atom starts a walk over its n stored arguments,
// one store write step for each single bit and each pair bit. A clear command and
// reset both start a sweep that zeroes the store one bit per cycle over all
// MAX_PREDICATES*MAX_ARITY*MAX_OBJECTS*(1 + MAX_ARITY*MAX_OBJECTS) bits
// (66560 at the defaults); busy stays high throughout. Results cannot be held
// off by the receiver.
module pair_assignment_bitmap_set
    import pab_pkg::*;
#(
    parameter int MAX_PREDICATES = DEF_MAX_PREDICATES,
    parameter int MAX_ARITY      = DEF_MAX_ARITY,
    parameter int MAX_OBJECTS    = DEF_MAX_OBJECTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [FIELD_W-1:0] predicate,
    input  logic [2:0]         arity,
    input  logic               negated,
    input  logic               term_is_variable,
    input  logic [FIELD_W-1:0] object_num,
    input  logic [FIELD_W-1:0] param_index,
    input  logic [FIELD_W-1:0] second_param,
    input  logic [FIELD_W-1:0] partner_object,
    input  logic               binding_is_edge,
    input  logic               last_term,
    input  logic               last_literal,
    output logic               result_valid,
    output logic               all_consistent
);

    localparam int SINGLE_BITS = MAX_PREDICATES * MAX_ARITY * MAX_OBJECTS;
    localparam int PAIR_BITS   = SINGLE_BITS * MAX_ARITY * MAX_OBJECTS;
    localparam int DEPTH       = SINGLE_BITS + PAIR_BITS;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int AW          = (MAX_ARITY > 1) ? $clog2(MAX_ARITY) : 1;

    state_t state_reg, state_next;
    store_ctl_t ctl;

    logic accept;
    logic clearing;
    logic rdata;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;

    // Binding.
    logic [FIELD_W-1:0] bp0_reg, bp1_reg, bo0_reg, bo1_reg;
    logic               edge_reg;

    // Atom insertion.
    logic [FIELD_W-1:0] buf_reg [MAX_ARITY];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [FIELD_W-1:0] ins_pred_reg;
    logic [LIMIT_W-1:0] ins_n_reg;
    logic [LIMIT_W-1:0] ins_n_next;
    logic [AW-1:0]      i_reg, j_reg;
    logic [FIELD_W-1:0] oi_reg;
    logic [FIELD_W-1:0] obj_j;
    logic               j_more, i_more;

    // Literal resolution and evaluation.
    logic [LIMIT_W-1:0] a_lim;
    logic [COUNT_W-1:0] tp_reg;
    logic [1:0]         rv_reg;
    logic [AW-1:0]      rpos_reg [2];
    logic [FIELD_W-1:0] robj_reg [2];
    logic               found;
    logic [FIELD_W-1:0] found_obj;
    logic [FIELD_W-1:0] lit_pred_reg;
    logic [LIMIT_W-1:0] lit_a_reg;
    logic               lit_neg_reg;
    logic               lit_last_reg;
    logic               list_failed_reg;
    logic               rd_pred_ok, rd_obj0_ok, rd_obj1_ok, use_pair;
    logic               bit_val, fail_now;
    logic               result_valid_reg, all_consistent_reg;

    assign busy   = (state_reg != ST_IDLE) || clearing;
    assign accept = start && !busy;

    assign a_lim = (int'(arity) > MAX_ARITY) ? LIMIT_W'(MAX_ARITY) : LIMIT_W'(arity);
    assign count_next = (count_reg < COUNT_W'(7)) ? count_reg + 1'b1 : count_reg;
    assign ins_n_next = ({1'b0, count_next} < a_lim) ? {1'b0, count_next} : a_lim;

    always_comb
    begin
        found     = 1'b0;
        found_obj = object_num;
        if (!term_is_variable)
            found = 1'b1;
        else if (bp0_reg == param_index)
        begin
            found     = 1'b1;
            found_obj = bo0_reg;
        end
        else if (edge_reg && bp1_reg == param_index)
        begin
            found     = 1'b1;
            found_obj = bo1_reg;
        end
    end

    // Insertion walk: j == i writes the single bit, j > i a pair bit.
    assign obj_j  = buf_reg[j_reg];
    assign j_more = ({1'b0, j_reg} + 1'b1) < ins_n_reg;
    assign i_more = ({1'b0, i_reg} + 1'b1) < ins_n_reg;

    always_comb
    begin
        if (j_reg == i_reg)
            waddr = ((ADDR_W'(ins_pred_reg) * ADDR_W'(MAX_ARITY) + ADDR_W'(i_reg))
                     * ADDR_W'(MAX_OBJECTS)) + ADDR_W'(obj_j);
        else
            waddr = ADDR_W'(SINGLE_BITS)
                  + ((((ADDR_W'(ins_pred_reg) * ADDR_W'(MAX_ARITY) + ADDR_W'(i_reg))
                       * ADDR_W'(MAX_ARITY) + ADDR_W'(j_reg))
                      * ADDR_W'(MAX_OBJECTS) + ADDR_W'(oi_reg))
                     * ADDR_W'(MAX_OBJECTS)) + ADDR_W'(obj_j);
    end

    assign rd_pred_ok = int'(lit_pred_reg) < MAX_PREDICATES;
    assign rd_obj0_ok = int'(robj_reg[0]) < MAX_OBJECTS;
    assign rd_obj1_ok = int'(robj_reg[1]) < MAX_OBJECTS;
    assign use_pair   = edge_reg && rv_reg[1];

    always_comb
    begin
        if (!(rd_pred_ok && rd_obj0_ok && (!use_pair || rd_obj1_ok)))
            raddr = '0;
        else if (use_pair)
            raddr = ADDR_W'(SINGLE_BITS)
                  + ((((ADDR_W'(lit_pred_reg) * ADDR_W'(MAX_ARITY) + ADDR_W'(rpos_reg[0]))
                       * ADDR_W'(MAX_ARITY) + ADDR_W'(rpos_reg[1]))
                      * ADDR_W'(MAX_OBJECTS) + ADDR_W'(robj_reg[0]))
                     * ADDR_W'(MAX_OBJECTS)) + ADDR_W'(robj_reg[1]);
        else
            raddr = ((ADDR_W'(lit_pred_reg) * ADDR_W'(MAX_ARITY) + ADDR_W'(rpos_reg[0]))
                     * ADDR_W'(MAX_OBJECTS)) + ADDR_W'(robj_reg[0]);
    end

    always_comb
    begin
        bit_val  = rdata && rd_pred_ok && rd_obj0_ok && (!use_pair || rd_obj1_ok);
        fail_now = 1'b0;
        if (rv_reg[0])
        begin
            if (!edge_reg)
            begin
                if (!(lit_neg_reg && lit_a_reg != LIMIT_W'(1)))
                    fail_now = (lit_neg_reg == bit_val);
            end
            else if (!lit_neg_reg)
                fail_now = !bit_val;
            else
                fail_now = bit_val && (lit_a_reg == LIMIT_W'(1)
                           || (lit_a_reg == LIMIT_W'(2) && rv_reg[1]));
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && last_term)
                begin
                    if (op == OP_INSERT && int'(predicate) < MAX_PREDICATES
                        && ins_n_next != '0)
                        state_next = ST_INSERT;
                    else if (op == OP_LITERAL)
                        state_next = ST_READ;
                end
            end
            ST_INSERT:
            begin
                if (!j_more && !i_more)
                    state_next = ST_IDLE;
            end
            ST_READ:
                state_next = ST_EVAL;
            ST_EVAL:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:
                ctl.clear_start = accept && (op == OP_CLEAR);
            ST_INSERT:
            begin
                if (j_reg == i_reg)
                    ctl.wr_en = int'(obj_j) < MAX_OBJECTS;
                else
                    ctl.wr_en = int'(obj_j) < MAX_OBJECTS && int'(oi_reg) < MAX_OBJECTS;
            end
            default:
                ctl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            count_reg          <= '0;
            bp0_reg            <= '0;
            bp1_reg            <= '0;
            bo0_reg            <= '0;
            bo1_reg            <= '0;
            edge_reg           <= 1'b0;
            tp_reg             <= '0;
            rv_reg             <= '0;
            list_failed_reg    <= 1'b0;
            result_valid_reg   <= 1'b0;
            all_consistent_reg <= 1'b0;
            i_reg              <= '0;
            j_reg              <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= 1'b0;
            if (accept && op == OP_INSERT)
                count_reg <= last_term ? '0 : count_next;
            if (accept && op == OP_BIND)
            begin
                bp0_reg  <= param_index;
                bo0_reg  <= object_num;
                bp1_reg  <= binding_is_edge ? second_param : '0;
                bo1_reg  <= binding_is_edge ? partner_object : '0;
                edge_reg <= binding_is_edge;
            end
            if (accept && op == OP_LITERAL)
            begin
                if ({1'b0, tp_reg} < a_lim && !rv_reg[1] && found)
                begin
                    if (rv_reg[0])
                        rv_reg[1] <= 1'b1;
                    else
                        rv_reg[0] <= 1'b1;
                end
                if (last_term)
                    tp_reg <= '0;
                else if (tp_reg < COUNT_W'(7))
                    tp_reg <= tp_reg + 1'b1;
            end
            if (accept && op == OP_INSERT && last_term)
            begin
                i_reg <= '0;
                j_reg <= '0;
            end
            else if (state_reg == ST_INSERT)
            begin
                if (j_more)
                    j_reg <= j_reg + 1'b1;
                else
                begin
                    i_reg <= i_reg + 1'b1;
                    j_reg <= i_reg + 1'b1;
                end
            end
            if (state_reg == ST_EVAL)
            begin
                rv_reg <= '0;
                if (lit_last_reg)
                begin
                    result_valid_reg   <= 1'b1;
                    all_consistent_reg <= !(list_failed_reg || fail_now);
                    list_failed_reg    <= 1'b0;
                end
                else
                    list_failed_reg <= list_failed_reg || fail_now;
            end
        end
    end

    // Payload registers; the control bits above say when they mean anything.
    always_ff @(posedge clk)
    begin
        if (accept && op == OP_INSERT)
        begin
            if (int'(count_reg) < MAX_ARITY)
                buf_reg[count_reg[AW-1:0]] <= object_num;
            if (last_term)
            begin
                ins_pred_reg <= predicate;
                ins_n_reg    <= ins_n_next;
            end
        end
        if (state_reg == ST_INSERT && j_reg == i_reg)
            oi_reg <= obj_j;
        if (accept && op == OP_LITERAL)
        begin
            if ({1'b0, tp_reg} < a_lim && !rv_reg[1] && found)
            begin
                if (rv_reg[0])
                begin
                    rpos_reg[1] <= tp_reg[AW-1:0];
                    robj_reg[1] <= found_obj;
                end
                else
                begin
                    rpos_reg[0] <= tp_reg[AW-1:0];
                    robj_reg[0] <= found_obj;
                end
            end
            if (last_term)
            begin
                lit_pred_reg <= predicate;
                lit_a_reg    <= a_lim;
                lit_neg_reg  <= negated;
                lit_last_reg <= last_literal;
            end
        end
    end

    pab_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .waddr    (waddr),
        .raddr    (raddr),
        .rdata    (rdata),
        .clearing (clearing)
    );

    assign result_valid   = result_valid_reg;
    assign all_consistent = all_consistent_reg;

    a_write_only_inserting: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_en |-> state_reg == ST_INSERT)
        else $error("store write outside insertion");

    a_result_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg) == ST_EVAL)
        else $error("result beat without evaluation");

    a_clear_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> state_reg == ST_IDLE)
        else $error("sweep overlaps a command");

    a_read_then_eval: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> state_reg == ST_EVAL)
        else $error("store read not followed by evaluation");

endmodule

### dv/tb_top.sv
// Self-checking testbench for pair_assignment_bitmap_set: directed and random command
// streams, with expected verdicts from an in-bench model of the store and literal checks.
// Depends on pab_pkg and the RTL of pair_assignment_bitmap_set.
module tb_top
    import pab_pkg::*;
();

    localparam int NPRED  = DEF_MAX_PREDICATES;
    localparam int NARITY = DEF_MAX_ARITY;
    localparam int NOBJ   = DEF_MAX_OBJECTS;
    localparam int SINGLE_N = NPRED * NARITY * NOBJ;
    localparam int STORE_N  = SINGLE_N + NPRED * NARITY * NARITY * NOBJ * NOBJ;
    localparam int ITEM_TARGET = 1250;

    typedef struct {
        op_t              op;
        logic [3:0]       pred;
        logic [2:0]       arity;
        logic             neg;
        logic             is_var;
        logic [3:0]       obj;
        logic [3:0]       par;
        logic [3:0]       par2;
        logic [3:0]       obj2;
        logic             edge_bind;
        logic             lt;
        logic             ll;
        int               gap;
        bit               drain;
    } cmd_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] op;
    logic [3:0] predicate;
    logic [2:0] arity;
    logic negated;
    logic term_is_variable;
    logic [3:0] object_num;
    logic [3:0] param_index;
    logic [3:0] second_param;
    logic [3:0] partner_object;
    logic binding_is_edge;
    logic last_term;
    logic last_literal;
    logic result_valid;
    logic all_consistent;

    pair_assignment_bitmap_set i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .predicate(predicate), .arity(arity), .negated(negated),
        .term_is_variable(term_is_variable), .object_num(object_num),
        .param_index(param_index), .second_param(second_param),
        .partner_object(partner_object), .binding_is_edge(binding_is_edge),
        .last_term(last_term), .last_literal(last_literal),
        .result_valid(result_valid), .all_consistent(all_consistent)
    );

    cmd_t pending_cmds[$];
    bit   verdict_q[$];
    int   errors = 0;
    int   pushed = 0;
    int   accepted = 0;
    int   verdicts_seen = 0;
    int   verdicts_failed = 0;
    int   clears_queued = 0;
    bit   burst = 0;

    // Model state.
    logic [STORE_N-1:0] store_bits;
    logic [3:0] arg_buf[NARITY];
    int unsigned arg_count;
    logic [3:0] bnd_par[2];
    logic [3:0] bnd_obj[2];
    bit bnd_edge;
    bit rv[2];
    int unsigned rpos[2];
    logic [3:0] robj[2];
    int unsigned term_pos;
    bit list_bad;

    function automatic int sidx(int pr, int p, int o);
        return (pr * NARITY + p) * NOBJ + o;
    endfunction

    function automatic int pidx(int pr, int p1, int p2, int o1, int o2);
        return SINGLE_N + ((((pr * NARITY + p1) * NARITY + p2) * NOBJ + o1) * NOBJ + o2);
    endfunction

    function automatic bit literal_fails(int pr, int a, bit ng);
        bit b;
        if (!rv[0])
            return 0;
        if (!bnd_edge)
        begin
            if (ng && a != 1)
                return 0;
            b = store_bits[sidx(pr, rpos[0], robj[0])];
            return ng == b;
        end
        if (ng && a != 1 && a != 2)
            return 0;
        if (rv[1])
            b = store_bits[pidx(pr, rpos[0], rpos[1], robj[0], robj[1])];
        else
            b = store_bits[sidx(pr, rpos[0], robj[0])];
        if (!ng)
            return !b;
        return b && (a == 1 || (a == 2 && rv[1]));
    endfunction

    // Applies one accepted beat to the model and queues a verdict when one is due.
    task automatic predict_verdict(cmd_t c);
        int a;
        int n;
        bit found;
        logic [3:0] value;
        int k;
        a = (c.arity > NARITY) ? NARITY : c.arity;
        case (c.op)
            OP_INSERT:
            begin
                if (arg_count < NARITY)
                    arg_buf[arg_count] = c.obj;
                if (arg_count < 7)
                    arg_count++;
                if (c.lt)
                begin
                    n = (arg_count < a) ? arg_count : a;
                    for (int i = 0; i < n; i++)
                    begin
                        store_bits[sidx(c.pred, i, arg_buf[i])] = 1'b1;
                        for (int j = i + 1; j < n; j++)
                            store_bits[pidx(c.pred, i, j, arg_buf[i], arg_buf[j])] = 1'b1;
                    end
                    arg_count = 0;
                end
            end
            OP_BIND:
            begin
                bnd_par[0] = c.par;
                bnd_obj[0] = c.obj;
                bnd_par[1] = c.edge_bind ? c.par2 : 4'd0;
                bnd_obj[1] = c.edge_bind ? c.obj2 : 4'd0;
                bnd_edge = c.edge_bind;
            end
            OP_CLEAR: store_bits = '0;
            default:
            begin
                if (term_pos < a && !rv[1])
                begin
                    found = 0;
                    value = '0;
                    if (!c.is_var)
                    begin
                        found = 1;
                        value = c.obj;
                    end
                    else if (bnd_par[0] == c.par)
                    begin
                        found = 1;
                        value = bnd_obj[0];
                    end
                    else if (bnd_edge && bnd_par[1] == c.par)
                    begin
                        found = 1;
                        value = bnd_obj[1];
                    end
                    if (found)
                    begin
                        k = rv[0] ? 1 : 0;
                        rv[k] = 1;
                        rpos[k] = term_pos;
                        robj[k] = value;
                    end
                end
                if (term_pos < 7)
                    term_pos++;
                if (c.lt)
                begin
                    if (literal_fails(c.pred, a, c.neg))
                        list_bad = 1;
                    rv[0] = 0;
                    rv[1] = 0;
                    term_pos = 0;
                    if (c.ll)
                    begin
                        verdict_q.push_back(!list_bad);
                        list_bad = 0;
                    end
                end
            end
        endcase
    endtask

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int r;
        c.op = op_t'($urandom_range(0, 3));
        c.pred = 4'($urandom);
        c.arity = 3'($urandom);
        c.neg = 1'($urandom);
        c.is_var = 1'($urandom);
        c.obj = 4'($urandom);
        c.par = 4'($urandom);
        c.par2 = 4'($urandom);
        c.obj2 = 4'($urandom);
        c.edge_bind = 1'($urandom);
        c.lt = 1'($urandom);
        c.ll = 1'($urandom);
        c.drain = 0;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            c.gap = 0;
        else if (r < 92)
            c.gap = $urandom_range(1, 3);
        else
            c.gap = $urandom_range(10, 40);
        return c;
    endfunction

    task automatic push_cmd(cmd_t c);
        pending_cmds.push_back(c);
        pushed++;
    endtask

    task automatic push_drain();
        cmd_t c;
        c = rand_cmd();
        c.drain = 1;
        pending_cmds.push_back(c);
    endtask

    task automatic push_atom(int pr, int ar, int nargs, int omax);
        cmd_t c;
        for (int i = 0; i < nargs; i++)
        begin
            c = rand_cmd();
            c.op = OP_INSERT;
            c.pred = 4'(pr);
            c.arity = 3'(ar);
            c.obj = 4'($urandom_range(0, omax));
            c.lt = (i == nargs - 1);
            push_cmd(c);
        end
    endtask

    task automatic push_bind(bit ed, int p0, int o0, int p1, int o1);
        cmd_t c;
        c = rand_cmd();
        c.op = OP_BIND;
        c.edge_bind = ed;
        c.par = 4'(p0);
        c.obj = 4'(o0);
        c.par2 = 4'(p1);
        c.obj2 = 4'(o1);
        push_cmd(c);
    endtask

    task automatic push_literal(int pr, int ar, bit ng, int nterms, bit last_l, int pmax,
                                int omax);
        cmd_t c;
        for (int i = 0; i < nterms; i++)
        begin
            c = rand_cmd();
            c.op = OP_LITERAL;
            c.pred = 4'(pr);
            c.arity = 3'(ar);
            c.neg = ng;
            c.par = 4'($urandom_range(0, pmax));
            c.obj = 4'($urandom_range(0, omax));
            c.lt = (i == nterms - 1);
            c.ll = last_l;
            push_cmd(c);
        end
    endtask

    task automatic push_clear();
        cmd_t c;
        c = rand_cmd();
        c.op = OP_CLEAR;
        push_cmd(c);
        clears_queued++;
    endtask

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Driver: one command per beat, with the gap held in the command before the next one.
    cmd_t cur;
    int   gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_verdict(cur);
                accepted++;
                gap_left = cur.gap;
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() > 0 && pending_cmds[0].drain)
                begin
                    if (verdict_q.size() == 0 && !busy)
                        void'(pending_cmds.pop_front());
                    start <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cur = pending_cmds.pop_front();
                    start <= 1'b1;
                    op <= cur.op;
                    predicate <= cur.pred;
                    arity <= cur.arity;
                    negated <= cur.neg;
                    term_is_variable <= cur.is_var;
                    object_num <= cur.obj;
                    param_index <= cur.par;
                    second_param <= cur.par2;
                    partner_object <= cur.obj2;
                    binding_is_edge <= cur.edge_bind;
                    last_term <= cur.lt;
                    last_literal <= cur.ll;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed verdict is matched against the oldest expected one.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("unexpected beat: all_consistent=%0b", all_consistent);
                errors++;
            end
            else
            begin
                if (all_consistent !== verdict_q[0])
                begin
                    $error("all_consistent mismatch: expected %0b actual %0b",
                           verdict_q[0], all_consistent);
                    errors++;
                end
                if (!verdict_q[0])
                    verdicts_failed++;
                void'(verdict_q.pop_front());
                verdicts_seen++;
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int r;
        int ar;
        int nt;
        int nlit;
        cmd_t c;
        start = 1'b0;
        op = '0;
        predicate = '0;
        arity = '0;
        negated = 1'b0;
        term_is_variable = 1'b0;
        object_num = '0;
        param_index = '0;
        second_param = '0;
        partner_object = '0;
        binding_is_edge = 1'b0;
        last_term = 1'b0;
        last_literal = 1'b0;
        store_bits = '0;
        for (int i = 0; i < NARITY; i++)
            arg_buf[i] = '0;
        arg_count = 0;
        bnd_par = '{0, 0};
        bnd_obj = '{0, 0};
        bnd_edge = 0;
        rv = '{0, 0};
        rpos = '{0, 0};
        robj = '{0, 0};
        term_pos = 0;
        list_bad = 0;
        rst_n = 1'b0;

        // Directed part: full and empty atoms, short and overlong atoms, both binding
        // forms, negation rules, unbound variables, terms past the arity, a clear.
        push_atom(15, 4, 4, 15);
        push_atom(3, 0, 1, 15);
        push_atom(2, 3, 2, 1);
        push_atom(1, 7, 6, 1);
        push_bind(0, 15, 15, 0, 0);
        push_literal(15, 1, 0, 1, 0, 15, 15);
        push_literal(3, 0, 1, 1, 0, 15, 15);
        push_literal(2, 1, 1, 2, 1, 0, 1);
        push_bind(1, 0, 1, 15, 0);
        push_literal(1, 2, 0, 2, 0, 15, 1);
        push_literal(1, 2, 1, 3, 0, 15, 1);
        push_literal(1, 7, 1, 7, 1, 15, 1);
        push_drain();
        push_clear();
        push_literal(1, 2, 0, 1, 1, 15, 1);
        push_drain();

        while (pushed < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                burst = !burst;
            if (r < 1 && clears_queued < 3)
                push_clear();
            else if (r < 30)
            begin
                ar = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
                nt = (ar == 0) ? 1 : ar + $urandom_range(0, 2) - ($urandom_range(0, 3) == 0);
                if (nt < 1)
                    nt = 1;
                push_atom($urandom_range(0, 3), ar, nt, 3);
            end
            else if (r < 45)
                push_bind(1'($urandom), $urandom_range(0, 3), $urandom_range(0, 3),
                          $urandom_range(0, 3), $urandom_range(0, 3));
            else if (r < 90)
            begin
                nlit = $urandom_range(1, 3);
                for (int l = 0; l < nlit; l++)
                begin
                    ar = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
                    nt = (ar == 0) ? 1 : ar + $urandom_range(0, 1) - ($urandom_range(0, 3) == 0);
                    if (nt < 1)
                        nt = 1;
                    push_literal($urandom_range(0, 3), ar, 1'($urandom), nt, l == nlit - 1,
                                 4, 3);
                end
            end
            else
            begin
                c = rand_cmd();
                if (c.op == OP_CLEAR)
                    c.op = OP_LITERAL;
                push_cmd(c);
            end
            if ($urandom_range(0, 99) == 0)
                push_drain();
        end
        // Close any open literal list so the tail yields a verdict.
        push_literal(0, 1, 0, 1, 1, 4, 3);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_cmds.size() == 0 && !start);
        wait (verdict_q.size() == 0 && !busy);
        repeat (50) @(posedge clk);
        $display("Ran %0d commands with %0d clears; checked %0d verdicts, %0d inconsistent.",
                 accepted, clears_queued, verdicts_seen, verdicts_failed);
        if (errors == 0 && verdict_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
